### design/zmabe_pkg.sv
// Package: shared types, codes and constants for the Z-machine ALU/branch execute unit.
`default_nettype none
package zmabe_pkg;

  localparam int WORD_W      = 16;
  localparam int DISP_W      = 14;
  localparam int LEN_W       = 6;
  localparam int DIV_STAGES  = WORD_W;  // one quotient bit per stage

  // Instruction forms
  typedef enum logic [1:0] {
    KIND_2OP = 2'd0,
    KIND_1OP = 2'd1,
    KIND_0OP = 2'd2
  } kind_t;

  // Status codes
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_DIV_ZERO    = 2'd1,
    STATUS_NOT_HANDLED = 2'd2
  } status_t;

  // 2OP opcodes
  localparam logic [4:0] OP2_JE   = 5'd1;
  localparam logic [4:0] OP2_JL   = 5'd2;
  localparam logic [4:0] OP2_JG   = 5'd3;
  localparam logic [4:0] OP2_TEST = 5'd7;
  localparam logic [4:0] OP2_OR   = 5'd8;
  localparam logic [4:0] OP2_AND  = 5'd9;
  localparam logic [4:0] OP2_ADD  = 5'd20;
  localparam logic [4:0] OP2_SUB  = 5'd21;
  localparam logic [4:0] OP2_MUL  = 5'd22;
  localparam logic [4:0] OP2_DIV  = 5'd23;
  localparam logic [4:0] OP2_MOD  = 5'd24;

  // 1OP opcodes
  localparam logic [4:0] OP1_JZ   = 5'd0;
  localparam logic [4:0] OP1_RET  = 5'd11;
  localparam logic [4:0] OP1_JUMP = 5'd12;
  localparam logic [4:0] OP1_NOT  = 5'd15;

  // 0OP opcodes
  localparam logic [4:0] OP0_RTRUE  = 5'd0;
  localparam logic [4:0] OP0_RFALSE = 5'd1;

  // Branch offset bias and the two offsets that mean "return"
  localparam logic [WORD_W-1:0] BRANCH_BIAS = 16'd2;
  localparam logic [DISP_W-1:0] DISP_RFALSE = 14'd0;
  localparam logic [DISP_W-1:0] DISP_RTRUE  = 14'd1;

  // Result fields and divide fix-up flags that travel with a request
  typedef struct packed {
    logic [WORD_W-1:0] next_pc;
    logic              store_valid;
    logic [WORD_W-1:0] store_value;
    logic              return_valid;
    logic [WORD_W-1:0] return_value;
    status_t           status;
    logic              is_div;
    logic              is_mod;
    logic              q_neg;
    logic              r_neg;
  } ctl_t;

  // Divider working state: partial remainder, dividend/quotient shift word, divisor
  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] nq;
    logic [WORD_W-1:0] dvs;
  } div_state_t;

  // One restoring division step on magnitudes
  function automatic div_state_t div_step(div_state_t s);
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic            ge;
    div_state_t      r;
    trial = {s.rem, s.nq[WORD_W-1]};
    diff  = trial - {1'b0, s.dvs};
    ge    = (trial >= {1'b0, s.dvs});
    r.rem = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    r.nq  = {s.nq[WORD_W-2:0], ge};
    r.dvs = s.dvs;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/zmabe_in_if.sv
// Interface: decoded instruction request channel.
`default_nettype none
interface zmabe_in_if;
  import zmabe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [4:0]               opcode;
  logic [2:0]               arg_count;
  logic [WORD_W-1:0]        op_a;
  logic [WORD_W-1:0]        op_b;
  logic [WORD_W-1:0]        op_c;
  logic [WORD_W-1:0]        op_d;
  logic                     branch_sense;
  logic signed [DISP_W-1:0] branch_disp;
  logic [WORD_W-1:0]        instr_address;
  logic [LEN_W-1:0]         instr_bytes;

  modport source (
    output valid, kind, opcode, arg_count, op_a, op_b, op_c, op_d,
           branch_sense, branch_disp, instr_address, instr_bytes,
    input  ready
  );
  modport sink (
    input  valid, kind, opcode, arg_count, op_a, op_b, op_c, op_d,
           branch_sense, branch_disp, instr_address, instr_bytes,
    output ready
  );
endinterface
`default_nettype wire

### design/zmabe_out_if.sv
// Interface: execute result channel.
`default_nettype none
interface zmabe_out_if;
  import zmabe_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] next_pc;
  logic              store_valid;
  logic [WORD_W-1:0] store_value;
  logic              return_valid;
  logic [WORD_W-1:0] return_value;
  logic [1:0]        status;

  modport source (
    output valid, next_pc, store_valid, store_value, return_valid, return_value, status,
    input  ready
  );
  modport sink (
    input  valid, next_pc, store_valid, store_value, return_valid, return_value, status,
    output ready
  );
endinterface
`default_nettype wire

### design/zmabe_decode.sv
// Decode stage: condition, branch target, simple ALU results and divider setup.
`default_nettype none
module zmabe_decode
  import zmabe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  zmabe_in_if.sink    instr,
  output logic        valid,
  output ctl_t        ctl,
  output div_state_t  dstate
);

  logic [WORD_W-1:0]   a, b, c, d;
  logic [WORD_W-1:0]   fall;
  logic [WORD_W-1:0]   br_target;
  logic [WORD_W-1:0]   jump_target;
  logic [2*WORD_W-1:0] product;
  logic                is_branch;
  logic                cond;
  logic                take;
  ctl_t                ctl_next;
  div_state_t          dstate_next;

  // No request is taken while reset is held
  assign instr.ready = adv && !rst;

  assign a = instr.op_a;
  assign b = instr.op_b;
  assign c = instr.op_c;
  assign d = instr.op_d;

  // Program counter candidates
  assign fall        = instr.instr_address + {{(WORD_W-LEN_W){1'b0}}, instr.instr_bytes};
  assign br_target   = fall + {{(WORD_W-DISP_W){instr.branch_disp[DISP_W-1]}},
                               instr.branch_disp} - BRANCH_BIAS;
  assign jump_target = fall + a - BRANCH_BIAS;
  assign product     = a * b;

  // Opcode decode and condition evaluation
  always_comb begin
    ctl_next              = '0;
    ctl_next.next_pc      = fall;
    ctl_next.status       = STATUS_OK;
    is_branch             = 1'b0;
    cond                  = 1'b0;
    dstate_next.rem       = '0;
    dstate_next.nq        = a[WORD_W-1] ? (~a + 1'b1) : a;
    dstate_next.dvs       = b[WORD_W-1] ? (~b + 1'b1) : b;

    case (instr.kind)
      KIND_2OP: begin
        case (instr.opcode)
          OP2_JE: begin
            is_branch = 1'b1;
            cond = (instr.arg_count >= 3'd2 && a == b) ||
                   (instr.arg_count >= 3'd3 && a == c) ||
                   (instr.arg_count >= 3'd4 && a == d);
          end
          OP2_JL: begin
            is_branch = 1'b1;
            cond = $signed(a) < $signed(b);
          end
          OP2_JG: begin
            is_branch = 1'b1;
            cond = $signed(a) > $signed(b);
          end
          OP2_TEST: begin
            is_branch = 1'b1;
            cond = (a & b) == b;
          end
          OP2_OR: begin
            ctl_next.store_valid = 1'b1;
            ctl_next.store_value = a | b;
          end
          OP2_AND: begin
            ctl_next.store_valid = 1'b1;
            ctl_next.store_value = a & b;
          end
          OP2_ADD: begin
            ctl_next.store_valid = 1'b1;
            ctl_next.store_value = a + b;
          end
          OP2_SUB: begin
            ctl_next.store_valid = 1'b1;
            ctl_next.store_value = a - b;
          end
          OP2_MUL: begin
            ctl_next.store_valid = 1'b1;
            ctl_next.store_value = product[WORD_W-1:0];
          end
          OP2_DIV, OP2_MOD: begin
            if (b == '0) begin
              ctl_next.status = STATUS_DIV_ZERO;
            end else begin
              ctl_next.store_valid = 1'b1;
              ctl_next.is_div      = (instr.opcode == OP2_DIV);
              ctl_next.is_mod      = (instr.opcode == OP2_MOD);
              ctl_next.q_neg       = a[WORD_W-1] ^ b[WORD_W-1];
              ctl_next.r_neg       = a[WORD_W-1];
            end
          end
          default: ctl_next.status = STATUS_NOT_HANDLED;
        endcase
      end
      KIND_1OP: begin
        case (instr.opcode)
          OP1_JZ: begin
            is_branch = 1'b1;
            cond = (a == '0);
          end
          OP1_RET: begin
            ctl_next.return_valid = 1'b1;
            ctl_next.return_value = a;
          end
          OP1_JUMP: ctl_next.next_pc = jump_target;
          OP1_NOT: begin
            ctl_next.store_valid = 1'b1;
            ctl_next.store_value = ~a;
          end
          default: ctl_next.status = STATUS_NOT_HANDLED;
        endcase
      end
      KIND_0OP: begin
        case (instr.opcode)
          OP0_RTRUE: begin
            ctl_next.return_valid = 1'b1;
            ctl_next.return_value = {{(WORD_W-1){1'b0}}, 1'b1};
          end
          OP0_RFALSE: begin
            ctl_next.return_valid = 1'b1;
            ctl_next.return_value = '0;
          end
          default: ctl_next.status = STATUS_NOT_HANDLED;
        endcase
      end
      default: ctl_next.status = STATUS_NOT_HANDLED;
    endcase

    // Taken branch: return true/false for the two special offsets, else jump
    take = is_branch && (cond == instr.branch_sense);
    if (take) begin
      if (instr.branch_disp == DISP_RFALSE || instr.branch_disp == DISP_RTRUE) begin
        ctl_next.return_valid = 1'b1;
        ctl_next.return_value = {{(WORD_W-1){1'b0}}, instr.branch_disp[0]};
      end else begin
        ctl_next.next_pc = br_target;
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl    <= ctl_next;
      dstate <= dstate_next;
    end
  end

endmodule
`default_nettype wire

### design/zmabe_div.sv
// Divider pipeline: one restoring step per stage, result fields ride alongside.
`default_nettype none
module zmabe_div
  import zmabe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire ctl_t        in_ctl,
  input  wire div_state_t  in_dstate,
  output logic             out_valid,
  output ctl_t             out_ctl,
  output div_state_t       out_dstate
);

  logic       stg_valid  [DIV_STAGES];
  ctl_t       stg_ctl    [DIV_STAGES];
  div_state_t stg_dstate [DIV_STAGES];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stg_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      stg_valid[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        stg_valid[k] <= stg_valid[k-1];
      end
    end
  end

  // Payload and division steps
  always_ff @(posedge clk) begin
    if (adv) begin
      stg_ctl[0]    <= in_ctl;
      stg_dstate[0] <= div_step(in_dstate);
      for (int k = 1; k < DIV_STAGES; k++) begin
        stg_ctl[k]    <= stg_ctl[k-1];
        stg_dstate[k] <= div_step(stg_dstate[k-1]);
      end
    end
  end

  assign out_valid  = stg_valid[DIV_STAGES-1];
  assign out_ctl    = stg_ctl[DIV_STAGES-1];
  assign out_dstate = stg_dstate[DIV_STAGES-1];

endmodule
`default_nettype wire

### design/zmabe_finish.sv
// Output stage: sign fix-up of quotient/remainder, store mux and output register.
`default_nettype none
module zmabe_finish
  import zmabe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  output logic             adv,
  input  wire logic        in_valid,
  input  wire ctl_t        in_ctl,
  input  wire div_state_t  in_dstate,
  zmabe_out_if.source      result
);

  logic [WORD_W-1:0] quot;
  logic [WORD_W-1:0] remd;
  logic [WORD_W-1:0] store_value_next;

  // Whole pipe moves when the output register is empty or being taken
  assign adv = !result.valid || result.ready;

  assign quot = in_ctl.q_neg ? (~in_dstate.nq + 1'b1) : in_dstate.nq;
  assign remd = in_ctl.r_neg ? (~in_dstate.rem + 1'b1) : in_dstate.rem;

  always_comb begin
    if (in_ctl.is_div) begin
      store_value_next = quot;
    end else if (in_ctl.is_mod) begin
      store_value_next = remd;
    end else begin
      store_value_next = in_ctl.store_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.next_pc      <= in_ctl.next_pc;
      result.store_valid  <= in_ctl.store_valid;
      result.store_value  <= store_value_next;
      result.return_valid <= in_ctl.return_valid;
      result.return_value <= in_ctl.return_value;
      result.status       <= in_ctl.status;
    end
  end

endmodule
`default_nettype wire

### design/zmachine_alu_branch_execute_unit.sv
// Z-machine v3 ALU/branch execute unit: top level.
// Path: the decode register loads when a request is accepted, then come 16 divider
//   step stages and the output register.
// Throughput: one request per cycle while not stalled; the divider takes one quotient bit per stage.
// Stall: the whole pipe holds while the output register is full and not taken.
// Reset (rst, synchronous): clears all stage valid bits; no request taken during reset.
`default_nettype none
module zmachine_alu_branch_execute_unit
  import zmabe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  zmabe_in_if.sink    instr,
  zmabe_out_if.source result
);

  logic       adv;
  logic       dec_valid;
  ctl_t       dec_ctl;
  div_state_t dec_dstate;
  logic       div_valid;
  ctl_t       div_ctl;
  div_state_t div_dstate;

  zmabe_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .instr  (instr),
    .valid  (dec_valid),
    .ctl    (dec_ctl),
    .dstate (dec_dstate)
  );

  zmabe_div u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (dec_valid),
    .in_ctl     (dec_ctl),
    .in_dstate  (dec_dstate),
    .out_valid  (div_valid),
    .out_ctl    (div_ctl),
    .out_dstate (div_dstate)
  );

  zmabe_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_ctl    (div_ctl),
    .in_dstate (div_dstate),
    .result    (result)
  );

endmodule
`default_nettype wire
